[src/ffpa_pkg.sv]
// Shared types and constants for the first-fit partition allocator.
// Used by every module of the allocator; depends on nothing else.
`timescale 1ns / 1ps

package ffpa_pkg;

    // Default sizing of the partition table.
    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // Fixed widths of the external fields.
    localparam int ACTION_W = 1;
    localparam int SLOT_W   = 4;
    localparam int AMOUNT_W = 16;
    localparam int CHOSEN_W = 4;
    localparam int COUNT_W  = 5;

    // Transaction kinds carried by the action field.
    localparam logic [ACTION_W-1:0] ACT_LOAD    = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_REQUEST = 1'b1;

    // Sequencer states.
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

[src/ffpa_size_mem.sv]
// Partition size memory: one write port and one read port with registered read data.
// Depends on ffpa_pkg for the default sizing.
`timescale 1ns / 1ps

module ffpa_size_mem #(
    parameter int NUM_BLOCKS = ffpa_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = ffpa_pkg::SIZE_BITS_DEF,
    parameter int IDX_W      = $clog2(NUM_BLOCKS)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [IDX_W-1:0]     i_waddr,
    input  logic [SIZE_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [IDX_W-1:0]     i_raddr,
    output logic [SIZE_BITS-1:0] o_rdata
);
    import ffpa_pkg::*;

    logic [SIZE_BITS-1:0] r_mem [NUM_BLOCKS];
    logic [SIZE_BITS-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/ffpa_ctrl.sv]
// Allocation sequencer: accepts transactions, scans the size memory one entry a
// cycle, keeps the taken bits and registers the result. Depends on ffpa_pkg.
`timescale 1ns / 1ps

module ffpa_ctrl #(
    parameter int NUM_BLOCKS = ffpa_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = ffpa_pkg::SIZE_BITS_DEF,
    parameter int IDX_W      = $clog2(NUM_BLOCKS)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [ffpa_pkg::ACTION_W-1:0]     i_action,
    input  logic [IDX_W-1:0]                  i_slot,
    input  logic                              i_slot_ok,
    input  logic [SIZE_BITS-1:0]              i_amount,
    input  logic                              i_empty,
    input  logic [IDX_W-1:0]                  i_last,
    input  logic [SIZE_BITS-1:0]              i_rd_data,
    output logic                              o_busy,
    output logic                              o_mem_we,
    output logic [IDX_W-1:0]                  o_mem_waddr,
    output logic [SIZE_BITS-1:0]              o_mem_wdata,
    output logic                              o_mem_re,
    output logic [IDX_W-1:0]                  o_mem_raddr,
    output logic                              o_done,
    output logic                              o_granted,
    output logic [IDX_W-1:0]                  o_pick
);
    import ffpa_pkg::*;

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]      r_last;
    logic [SIZE_BITS-1:0]  r_amount;
    logic [NUM_BLOCKS-1:0] r_taken, n_taken;
    logic                  r_done, n_done;
    logic                  r_granted, n_granted;
    logic [IDX_W-1:0]      r_pick, n_pick;

    logic accept;
    logic is_load;
    logic scanning;
    logic hit;
    logic at_last;

    assign accept   = i_start && (r_state == ST_IDLE);
    assign is_load  = (i_action == ACT_LOAD);
    assign scanning = (r_state == ST_SCAN);
    assign at_last  = (r_idx == r_last);
    // The entry read last cycle fits when it is free and large enough.
    assign hit      = !r_taken[r_idx] && (i_rd_data >= r_amount);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && !is_load && !i_empty) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit || at_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Memory accesses, taken bits and result.
    always_comb begin
        o_mem_we    = accept && is_load && i_slot_ok;
        o_mem_waddr = i_slot;
        o_mem_wdata = i_amount;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;
        n_idx       = r_idx;
        n_taken     = r_taken;
        n_done      = 1'b0;
        n_granted   = 1'b0;
        n_pick      = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    if (is_load) begin
                        // A load frees the block it sizes.
                        if (i_slot_ok) begin
                            n_taken[i_slot] = 1'b0;
                        end
                        n_done    = 1'b1;
                        n_granted = i_slot_ok;
                    end else if (i_empty) begin
                        n_done = 1'b1;
                    end else begin
                        o_mem_re = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                // Fetch the following entry while the current one is checked.
                o_mem_re    = !at_last;
                o_mem_raddr = r_idx + 1'b1;
                n_idx       = r_idx + 1'b1;
                if (hit) begin
                    n_taken[r_idx] = 1'b1;
                    n_done         = 1'b1;
                    n_granted      = 1'b1;
                    n_pick         = r_idx;
                end else if (at_last) begin
                    n_done = 1'b1;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_taken <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_taken <= n_taken;
            r_done  <= n_done;
        end
    end

    // Scan position, request operands and result payload.
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_granted <= n_granted;
        r_pick    <= n_pick;
        if (accept) begin
            r_last   <= i_last;
            r_amount <= i_amount;
        end
    end

    assign o_busy    = scanning;
    assign o_done    = r_done;
    assign o_granted = r_granted;
    assign o_pick    = r_pick;

endmodule

[src/first_fit_partition_allocator_unit.sv]
// First-fit partition allocator, top level. Depends on ffpa_pkg, ffpa_size_mem, ffpa_ctrl.
// Results: a load, or a request with a zero block count, gives its result in the cycle after
// it is accepted; a request gives it in the cycle after the scan finds a fit or checks its last block.
// Occupancy: a load never makes the unit busy; a request keeps it busy while it scans k blocks, k at most
// min(block_count, NUM_BLOCKS), set by one size-memory read and compare per cycle.
// Reset (synchronous) frees every block and clears block_count; sizes are undefined until loaded.
`timescale 1ns / 1ps

module first_fit_partition_allocator_unit #(
    parameter int NUM_BLOCKS = ffpa_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = ffpa_pkg::SIZE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ffpa_pkg::ACTION_W-1:0] i_action,
    input  logic [ffpa_pkg::SLOT_W-1:0]   i_block_slot,
    input  logic [ffpa_pkg::AMOUNT_W-1:0] i_amount,
    output logic                          o_done,
    output logic                          o_granted,
    output logic [ffpa_pkg::CHOSEN_W-1:0] o_chosen_block,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ffpa_pkg::COUNT_W-1:0]  i_cfg_data
);
    import ffpa_pkg::*;

    localparam int IDX_W = $clog2(NUM_BLOCKS);

    logic [COUNT_W-1:0]   r_block_count;
    logic [31:0]          slot_wide;
    logic [31:0]          amount_wide;
    logic [31:0]          count_wide;
    logic [31:0]          last_wide;
    logic [31:0]          pick_wide;
    logic [IDX_W-1:0]     slot_idx;
    logic                 slot_ok;
    logic [SIZE_BITS-1:0] amount_cut;
    logic                 count_empty;
    logic [IDX_W-1:0]     last_idx;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [SIZE_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;
    logic [SIZE_BITS-1:0] mem_rdata;
    logic [IDX_W-1:0]     pick;

    // Configuration register; a write is always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= '0;
        end else if (i_cfg_valid) begin
            r_block_count <= i_cfg_data;
        end
    end

    // Fit the input fields to the table's index and size widths.
    assign slot_wide   = 32'(i_block_slot);
    assign slot_ok     = (slot_wide < 32'(NUM_BLOCKS));
    assign slot_idx    = slot_wide[IDX_W-1:0];
    assign amount_wide = 32'(i_amount);
    assign amount_cut  = amount_wide[SIZE_BITS-1:0];

    // Last block searched: the count clamped to the table depth, minus one.
    assign count_wide  = 32'(r_block_count);
    assign count_empty = (r_block_count == '0);
    assign last_wide   = (count_wide > 32'(NUM_BLOCKS)) ? 32'(NUM_BLOCKS - 1)
                                                        : (count_wide - 32'd1);
    assign last_idx    = last_wide[IDX_W-1:0];

    ffpa_size_mem #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W)
    ) u_size_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ffpa_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_action    (i_action),
        .i_slot      (slot_idx),
        .i_slot_ok   (slot_ok),
        .i_amount    (amount_cut),
        .i_empty     (count_empty),
        .i_last      (last_idx),
        .i_rd_data   (mem_rdata),
        .o_busy      (busy),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .o_done      (o_done),
        .o_granted   (o_granted),
        .o_pick      (pick)
    );

    // The reported index keeps the low bits of the block number.
    assign pick_wide      = 32'(pick);
    assign o_chosen_block = pick_wide[CHOSEN_W-1:0];

endmodule
